>>> rtl/fuzzy_subsequence_scorer_assert.svh
// Assertion helpers for the scorer RTL.
// Define ASSERT_OFF to compile them out.
`ifndef FUZZY_SUBSEQUENCE_SCORER_ASSERT_SVH
`define FUZZY_SUBSEQUENCE_SCORER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define FSS_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define FSS_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FSS_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons, msg)
`define FSS_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg)
`endif
`endif

>>> rtl/fss_pkg.sv
package fss_pkg;

  // Byte lane width of the candidate string and the query
  localparam int CHAR_W = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;
  localparam int QLEN_W      = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_CHARS  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_LENGTH = 1'd1;

  // Length bound of the candidate string and score format
  localparam int MAX_STRING      = 1024;
  localparam int SCORE_FRAC_BITS = 16;
  localparam int POS_W           = $clog2(MAX_STRING + 1);
  localparam int SCORE_W         = SCORE_FRAC_BITS + 1;

  // ASCII case fold: upper-case letters map to lower case
  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] f;
    f = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      f = c + 8'h20;
    end
    return f;
  endfunction

endpackage

>>> rtl/fss_if.sv
// Candidate string channel: one byte per beat
interface fss_char_if import fss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;
  logic              empty_string;

  modport source (output valid, character, last_char, empty_string, input ready);
  modport sink   (input valid, character, last_char, empty_string, output ready);
endinterface

// Result channel: one beat per candidate string
interface fss_result_if import fss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   window_length;
  logic [POS_W-1:0]   string_length;
  logic [SCORE_W-1:0] match_score;
  logic               too_long;

  modport source (output valid, window_length, string_length, match_score, too_long,
                  input ready);
  modport sink   (input valid, window_length, string_length, match_score, too_long,
                  output ready);
endinterface

>>> rtl/fuzzy_subsequence_scorer.sv
// Channel       Dir  Beat
// char_stream   in   character, last_char, empty_string
// result        out  window_length, string_length, match_score, too_long
// cfg_*         in   write enable, register index, data (query_chars, query_length)
//
// Each byte is taken from the beat, then matched against each query position, up to
// the query length capped at MAX_QUERY, on the single compare/update unit.
// With an empty query, and for bytes past MAX_STRING, no query positions are run.
// The last byte adds a finish step, then one multiply and SCORE_FRAC_BITS + 4 divide
// steps in the divider and a hand-over of the quotient (only when there is a match),
// then the result is posted.
// Reset is synchronous; it clears the query, position, prefix flags, window and overflow.
// char_stream is ready only between bytes; a result held on a stalled output
// does not block the next string's bytes until that string's own result is due.
module fuzzy_subsequence_scorer import fss_pkg::*; #(
  parameter int MAX_QUERY = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  fss_char_if.sink               char_stream,
  fss_result_if.source           result
);

  `include "fuzzy_subsequence_scorer_assert.svh"

  localparam int IDX_W   = $clog2(MAX_STRING);
  localparam int KW      = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int NUM_W   = SCORE_FRAC_BITS + QLEN_W;

  localparam logic [SCORE_W-1:0] SCORE_ONE = {1'b1, {SCORE_FRAC_BITS{1'b0}}};

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_FINISH = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  // Configuration
  logic [CFG_DATA_W-1:0] query_chars;
  logic [QLEN_W-1:0]     query_length;
  logic [QLEN_W-1:0]     qlen;

  // Per-string state
  logic [2:0]       state;
  logic [KW-1:0]    k;
  logic [CHAR_W-1:0] ch;
  logic             last;
  logic [IDX_W-1:0] prefix_start [MAX_QUERY];
  logic [MAX_QUERY-1:0] prefix_valid;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] best_window;
  logic             overflow_seen;

  // Staged result
  logic [POS_W-1:0]   res_window;
  logic [POS_W-1:0]   res_length;
  logic [SCORE_W-1:0] res_score;
  logic               res_too_long;

  // Compare/update unit
  logic             q_match;
  logic             prev_ok;
  logic             hit;
  logic             at_top;
  logic [IDX_W-1:0] new_start;
  logic [IDX_W-1:0] pos_idx;
  logic [POS_W-1:0] win;

  logic             accept;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_chars  <= '0;
      query_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_QUERY_CHARS:  query_chars  <= cfg_data;
        REG_QUERY_LENGTH: query_length <= cfg_data[QLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign qlen = (query_length > QLEN_W'(MAX_QUERY)) ? QLEN_W'(MAX_QUERY) : query_length;

  assign char_stream.ready = (state == ST_IDLE);
  assign accept            = char_stream.valid && char_stream.ready;

  // One query position per cycle, from the top prefix down
  always_comb begin
    pos_idx   = position[IDX_W-1:0];
    q_match   = fold_char(query_chars[8*k +: 8]) == ch;
    prev_ok   = (k == '0) || prefix_valid[k - KW'(1)];
    hit       = q_match && prev_ok;
    new_start = (k == '0) ? pos_idx : prefix_start[k - KW'(1)];
    at_top    = QLEN_W'(k) == (qlen - QLEN_W'(1));
    win       = POS_W'(pos_idx - new_start) + POS_W'(1);
  end

  assign div_start = (state == ST_FINISH) && (qlen != '0) && (position != '0) &&
                     (best_window != '0);

  fss_divider #(
    .NUM_W (NUM_W),
    .FAC_W (POS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    ({qlen, {SCORE_FRAC_BITS{1'b0}}}),
    .factor_a (best_window),
    .factor_b (position),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      k             <= '0;
      prefix_valid  <= '0;
      position      <= '0;
      best_window   <= '0;
      overflow_seen <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      if (result.ready && (state != ST_EMIT)) begin
        result.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ch   <= fold_char(char_stream.character);
            last <= char_stream.last_char;
            if (char_stream.empty_string) begin
              res_window   <= '0;
              res_length   <= '0;
              res_score    <= (qlen == '0) ? SCORE_ONE : '0;
              res_too_long <= 1'b0;
              state        <= ST_EMIT;
            end else if (position >= POS_W'(MAX_STRING)) begin
              overflow_seen <= 1'b1;
              state         <= char_stream.last_char ? ST_FINISH : ST_IDLE;
            end else if (qlen == '0) begin
              position <= position + POS_W'(1);
              state    <= char_stream.last_char ? ST_FINISH : ST_IDLE;
            end else begin
              k     <= KW'(qlen - QLEN_W'(1));
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            prefix_start[k] <= new_start;
            prefix_valid[k] <= 1'b1;
            if (at_top && (best_window == '0 || win < best_window)) begin
              best_window <= win;
            end
          end
          if (k == '0) begin
            position <= position + POS_W'(1);
            state    <= last ? ST_FINISH : ST_IDLE;
          end else begin
            k <= k - KW'(1);
          end
        end
        ST_FINISH: begin
          res_length   <= position;
          res_too_long <= overflow_seen;
          res_window   <= (qlen == '0) ? '0 : best_window;
          res_score    <= (qlen == '0) ? SCORE_ONE : '0;
          state        <= div_start ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          if (div_done) begin
            res_score <= div_quot[SCORE_W-1:0];
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Post when the output register is free, then start a fresh string
          if (!result.valid || result.ready) begin
            result.valid         <= 1'b1;
            result.window_length <= res_window;
            result.string_length <= res_length;
            result.match_score   <= res_score;
            result.too_long      <= res_too_long;
            prefix_valid         <= '0;
            position             <= '0;
            best_window          <= '0;
            overflow_seen        <= 1'b0;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `FSS_ASSERT_IMPL(a_post_from_emit, clk, rst, $rose(result.valid),
                   $past(state) == ST_EMIT, "result posted outside emit")
  `FSS_ASSERT_IMPL(a_overflow_len, clk, rst, result.valid && result.too_long,
                   result.string_length == POS_W'(MAX_STRING), "overflow with short length")
  `FSS_ASSERT_IMPL(a_window_fits, clk, rst, result.valid,
                   result.window_length <= result.string_length, "window longer than string")
  `FSS_ASSERT_IMPL(a_scan_in_range, clk, rst, state == ST_SCAN,
                   position < POS_W'(MAX_STRING), "matching past the length bound")

endmodule

>>> rtl/fss_divider.sv
`include "fuzzy_subsequence_scorer_assert.svh"

// Multiply two factors into a denominator, then restoring division,
// one quotient bit per cycle, MSB first.
module fss_divider #(
  parameter int NUM_W = 20,
  parameter int FAC_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [FAC_W-1:0] factor_a,
  input  logic [FAC_W-1:0] factor_b,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int DEN_W = 2 * FAC_W;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_MUL  = 2'd1;
  localparam logic [1:0] DV_RUN  = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [FAC_W-1:0] fac_a;
  logic [FAC_W-1:0] fac_b;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] dividend;

  logic [DEN_W:0]   rem_shift;
  logic             fits;
  logic [DEN_W:0]   diff;

  // One restoring step
  always_comb begin
    rem_shift = {rem, dividend[NUM_W-1]};
    fits      = rem_shift >= {1'b0, den};
    diff      = rem_shift - {1'b0, den};
  end

  // Pulse after the final division step
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == DV_RUN) && (cnt == CNT_W'(NUM_W - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        DV_IDLE: begin
          if (start) begin
            fac_a    <= factor_a;
            fac_b    <= factor_b;
            dividend <= numer;
            state    <= DV_MUL;
          end
        end
        DV_MUL: begin
          den   <= fac_a * fac_b;
          rem   <= '0;
          cnt   <= '0;
          state <= DV_RUN;
        end
        DV_RUN: begin
          rem      <= fits ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
          quotient <= {quotient[NUM_W-2:0], fits};
          dividend <= {dividend[NUM_W-2:0], 1'b0};
          cnt      <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(NUM_W - 1)) begin
            state <= DV_IDLE;
          end
        end
        default: begin
          state <= DV_IDLE;
        end
      endcase
    end
  end

  `FSS_ASSERT_IMPL(a_start_idle, clk, rst, start, state == DV_IDLE, "divider started while busy")
  `FSS_ASSERT_NEXT(a_mul_to_run, clk, rst, state == DV_MUL, state == DV_RUN,
                   "multiply step skipped")
  `FSS_ASSERT_IMPL(a_done_after_run, clk, rst, done, $past(state) == DV_RUN && state == DV_IDLE,
                   "done without a final division step")

endmodule
